/* hdl/asa_pkg.sv */
// shared codes, types and defaults for the aligned stack allocator
package asa_pkg;

    localparam int ADDR_WIDTH_DEF  = 32;
    localparam int CURVE_DEPTH_DEF = 256;

    localparam int FIELD_W     = 32;
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 168;

    // command codes
    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    // error codes
    localparam logic [2:0] ERR_NONE          = 3'd0;
    localparam logic [2:0] ERR_LOCKED        = 3'd1;
    localparam logic [2:0] ERR_BAD_ALIGN     = 3'd2;
    localparam logic [2:0] ERR_OVERFLOW      = 3'd3;
    localparam logic [2:0] ERR_NO_ROOM       = 3'd4;
    localparam logic [2:0] ERR_BASE_MISALIGN = 3'd5;
    localparam logic [2:0] ERR_FREE_MISMATCH = 3'd6;

    // curve warning codes
    localparam logic [1:0] WARN_NONE     = 2'd0;
    localparam logic [1:0] WARN_CAPACITY = 2'd1;
    localparam logic [1:0] WARN_MISMATCH = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_REGION_SIZE   = 2'd0;
    localparam logic [1:0] CFG_REGION_BASE   = 2'd1;
    localparam logic [1:0] CFG_EXECUTE_PHASE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    // flags handed from the front stage to the update stage
    typedef struct packed {
        logic [1:0] cmd;
        logic       bad_align;
        logic       round_ovf;
        logic       free_match;
    } stage_flags_t;

    // one result word, ok in the lowest bit
    typedef struct packed {
        logic [FIELD_W-1:0] peak_alignment;
        logic [FIELD_W-1:0] peak_offset;
        logic [1:0]         curve_warning;
        logic [FIELD_W-1:0] check_offset;
        logic [FIELD_W-1:0] restore_offset;
        logic [FIELD_W-1:0] address;
        logic [2:0]         error_code;
        logic               ok;
    } result_t;

endpackage

/* hdl/aligned_stack_allocator_core.sv */
// top level: stack bump allocator with alignment, peaks and curve check
// a taken word is registered in the front stage and the curve ram read, and its result
// is loaded into the output register once that is free; no new word is taken until
// the update of the offset state for it is done, and a stalled result holds the next word
// reset: aresetn synchronous, active low, clears offset, index, flags, peaks and config
// the curve ram is not cleared; entries are defined once written in counting phase
module aligned_stack_allocator_core #(
    parameter int ADDR_WIDTH  = asa_pkg::ADDR_WIDTH_DEF,
    parameter int CURVE_DEPTH = asa_pkg::CURVE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // command words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // request_size, request_alignment, free_restore, free_check (32 bits each)
    input  logic [asa_pkg::IN_TDATA_W-1:0]    s_tdata,
    // cmd
    input  logic [1:0]                        s_tuser,
    // result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // ok, error_code, address, restore_offset, check_offset, curve_warning,
    // peak_offset, peak_alignment, then zero fill
    output logic [asa_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [31:0]                       cfg_wdata
);

    localparam int IDX_W = (CURVE_DEPTH > 1) ? $clog2(CURVE_DEPTH) : 1;
    localparam int CNT_W = $clog2(CURVE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(CURVE_DEPTH);

    // configuration registers
    logic [ADDR_WIDTH-1:0] region_size_reg;
    logic [ADDR_WIDTH-1:0] region_base_reg;
    logic                  execute_phase_reg;

    // allocator state
    asa_pkg::state_t       state_reg, state_next;
    logic [ADDR_WIDTH-1:0] top_offset_reg, top_offset_next;
    logic                  usable_reg, usable_next;
    logic [CNT_W-1:0]      curve_index_reg, curve_index_next;
    logic                  curve_reported_reg, curve_reported_next;
    logic [ADDR_WIDTH-1:0] max_offset_reg, max_offset_next;
    logic [ADDR_WIDTH-1:0] max_align_reg, max_align_next;

    // output register
    logic                  m_tvalid_reg, m_tvalid_next;
    asa_pkg::result_t      result_reg, result_next;

    // front stage outputs
    asa_pkg::stage_flags_t flags_q;
    logic [ADDR_WIDTH-1:0] size_q, align_q, aligned_q, restore_q;

    // curve ram
    logic                  ram_we;
    logic [ADDR_WIDTH-1:0] ram_rdata;

    logic                  accept;
    logic                  complete;

    logic [ADDR_WIDTH:0]   next_sum;
    logic [ADDR_WIDTH-1:0] next_off;
    logic [ADDR_WIDTH-1:0] amask_q;
    logic                  curve_has_room;
    logic                  curve_match;
    logic [1:0]            warn;
    logic [2:0]            alloc_err;

    assign s_tready  = (state_reg == asa_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    // the update waits for the output register to be free
    assign complete  = (state_reg == asa_pkg::ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(asa_pkg::OUT_TDATA_W - $bits(asa_pkg::result_t)){1'b0}}, result_reg};

    asa_align #(
        .ADDR_WIDTH(ADDR_WIDTH)
    ) u_align (
        .aclk       (aclk),
        .load       (accept),
        .cmd        (s_tuser),
        .size       (ADDR_WIDTH'(s_tdata[31:0])),
        .align      (ADDR_WIDTH'(s_tdata[63:32])),
        .restore    (ADDR_WIDTH'(s_tdata[95:64])),
        .check      (ADDR_WIDTH'(s_tdata[127:96])),
        .top_offset (top_offset_reg),
        .flags_q    (flags_q),
        .size_q     (size_q),
        .align_q    (align_q),
        .aligned_q  (aligned_q),
        .restore_q  (restore_q)
    );

    // read at the current index when the word is taken; the write comes only at
    // the end of that word, and the state machine holds off the next read until then
    asa_ram #(
        .WIDTH(ADDR_WIDTH),
        .DEPTH(CURVE_DEPTH)
    ) u_curve_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (curve_index_reg[IDX_W-1:0]),
        .wdata (next_off),
        .re    (accept),
        .raddr (curve_index_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        // size add; a carry out means the end offset wraps
        next_sum       = {1'b0, aligned_q} + {1'b0, size_q};
        next_off       = next_sum[ADDR_WIDTH-1:0];
        amask_q        = align_q - ADDR_WIDTH'(1);
        curve_has_room = (curve_index_reg < DEPTH_CNT);
        curve_match    = curve_has_room && (ram_rdata == next_off);

        // errors in priority order
        if (!usable_reg) begin
            alloc_err = asa_pkg::ERR_LOCKED;
        end else if (flags_q.bad_align) begin
            alloc_err = asa_pkg::ERR_BAD_ALIGN;
        end else if (flags_q.round_ovf || next_sum[ADDR_WIDTH]) begin
            alloc_err = asa_pkg::ERR_OVERFLOW;
        end else if (execute_phase_reg && (next_off > region_size_reg)) begin
            alloc_err = asa_pkg::ERR_NO_ROOM;
        end else if (execute_phase_reg && ((region_base_reg & amask_q) != '0)) begin
            alloc_err = asa_pkg::ERR_BASE_MISALIGN;
        end else begin
            alloc_err = asa_pkg::ERR_NONE;
        end

        state_next          = state_reg;
        top_offset_next     = top_offset_reg;
        usable_next         = usable_reg;
        curve_index_next    = curve_index_reg;
        curve_reported_next = curve_reported_reg;
        max_offset_next     = max_offset_reg;
        max_align_next      = max_align_reg;
        ram_we              = 1'b0;
        warn                = asa_pkg::WARN_NONE;
        m_tvalid_next       = m_tvalid_reg && !m_tready;
        result_next         = result_reg;

        case (state_reg)
            asa_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = asa_pkg::ST_EXEC;
                end
            end
            asa_pkg::ST_EXEC: begin
                if (complete) begin
                    state_next    = asa_pkg::ST_IDLE;
                    m_tvalid_next = 1'b1;
                    result_next   = '0;

                    case (flags_q.cmd)
                        asa_pkg::CMD_ALLOC: begin
                            if (alloc_err == asa_pkg::ERR_NONE) begin
                                if (!execute_phase_reg) begin
                                    // counting: record the curve
                                    if (curve_has_room) begin
                                        ram_we           = 1'b1;
                                        curve_index_next = curve_index_reg + CNT_W'(1);
                                    end else if (!curve_reported_reg) begin
                                        curve_reported_next = 1'b1;
                                        warn                = asa_pkg::WARN_CAPACITY;
                                    end
                                end else begin
                                    // execution: verify against the curve
                                    if (curve_has_room) begin
                                        curve_index_next = curve_index_reg + CNT_W'(1);
                                    end
                                    if (!curve_match && !curve_reported_reg) begin
                                        curve_reported_next = 1'b1;
                                        warn                = asa_pkg::WARN_MISMATCH;
                                    end
                                end
                                top_offset_next = next_off;
                                if (align_q > max_align_reg) begin
                                    max_align_next = align_q;
                                end
                                if (next_off > max_offset_reg) begin
                                    max_offset_next = next_off;
                                end
                                result_next.ok             = 1'b1;
                                result_next.address        = execute_phase_reg ?
                                    32'(ADDR_WIDTH'(region_base_reg + aligned_q)) : '0;
                                result_next.restore_offset = 32'(top_offset_reg);
                                result_next.check_offset   = 32'(next_off);
                                result_next.curve_warning  = warn;
                            end else begin
                                result_next.error_code = alloc_err;
                            end
                        end
                        asa_pkg::CMD_FREE: begin
                            if (flags_q.free_match) begin
                                top_offset_next = restore_q;
                                result_next.ok  = 1'b1;
                            end else begin
                                usable_next            = 1'b0;
                                result_next.error_code = asa_pkg::ERR_FREE_MISMATCH;
                            end
                        end
                        asa_pkg::CMD_RESTART: begin
                            top_offset_next     = '0;
                            curve_index_next    = '0;
                            curve_reported_next = 1'b0;
                            usable_next         = 1'b1;
                            result_next.ok      = 1'b1;
                        end
                        default: begin
                            // unused command: plain zero result
                        end
                    endcase

                    result_next.peak_offset    = 32'(max_offset_next);
                    result_next.peak_alignment = 32'(max_align_next);
                end
            end
            default: begin
                state_next = asa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= asa_pkg::ST_IDLE;
            top_offset_reg     <= '0;
            usable_reg         <= 1'b1;
            curve_index_reg    <= '0;
            curve_reported_reg <= 1'b0;
            max_offset_reg     <= '0;
            max_align_reg      <= '0;
            m_tvalid_reg       <= 1'b0;
            region_size_reg    <= '0;
            region_base_reg    <= '0;
            execute_phase_reg  <= 1'b0;
        end else begin
            state_reg          <= state_next;
            top_offset_reg     <= top_offset_next;
            usable_reg         <= usable_next;
            curve_index_reg    <= curve_index_next;
            curve_reported_reg <= curve_reported_next;
            max_offset_reg     <= max_offset_next;
            max_align_reg      <= max_align_next;
            m_tvalid_reg       <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    asa_pkg::CFG_REGION_SIZE:   region_size_reg   <= ADDR_WIDTH'(cfg_wdata);
                    asa_pkg::CFG_REGION_BASE:   region_base_reg   <= ADDR_WIDTH'(cfg_wdata);
                    asa_pkg::CFG_EXECUTE_PHASE: execute_phase_reg <= cfg_wdata[0];
                    default: begin
                        // writes beyond the register list are dropped
                    end
                endcase
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        result_reg <= result_next;
    end

    // the curve index never runs past the store
    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        curve_index_reg <= DEPTH_CNT)
        else $error("curve index beyond store depth");

    // the curve ram is only written while a word completes in counting phase
    a_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (complete && !execute_phase_reg && curve_has_room))
        else $error("curve write outside counting completion");

    // every completion leaves a result word pending and the front free
    a_complete_out: assert property (@(posedge aclk) disable iff (!aresetn)
        complete |=> (m_tvalid && s_tready))
        else $error("completion did not load the output register");

    // locking only happens together with a free mismatch result
    a_lock_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(usable_reg) |-> (m_tvalid && !result_reg.ok &&
                               result_reg.error_code == asa_pkg::ERR_FREE_MISMATCH))
        else $error("lock without free mismatch");

    // a curve warning is raised once, at a completion
    a_warn_once: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(curve_reported_reg) |-> (m_tvalid && result_reg.curve_warning != '0))
        else $error("curve report without warning");

endmodule

/* hdl/asa_ram.sv */
// generic single-port-write, registered-read ram
module asa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/asa_align.sv */
// front stage: alignment check, rounding and free compare, registered
module asa_align #(
    parameter int ADDR_WIDTH = asa_pkg::ADDR_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      load,
    input  logic [1:0]                cmd,
    input  logic [ADDR_WIDTH-1:0]     size,
    input  logic [ADDR_WIDTH-1:0]     align,
    input  logic [ADDR_WIDTH-1:0]     restore,
    input  logic [ADDR_WIDTH-1:0]     check,
    input  logic [ADDR_WIDTH-1:0]     top_offset,
    output asa_pkg::stage_flags_t     flags_q,
    output logic [ADDR_WIDTH-1:0]     size_q,
    output logic [ADDR_WIDTH-1:0]     align_q,
    output logic [ADDR_WIDTH-1:0]     aligned_q,
    output logic [ADDR_WIDTH-1:0]     restore_q
);

    logic [ADDR_WIDTH-1:0] amask;
    logic [ADDR_WIDTH:0]   round_sum;
    asa_pkg::stage_flags_t flags_d;

    always_comb begin
        amask     = align - ADDR_WIDTH'(1);
        round_sum = {1'b0, top_offset} + {1'b0, amask};
        flags_d.cmd        = cmd;
        flags_d.bad_align  = (align == '0) || ((align & amask) != '0);
        flags_d.round_ovf  = round_sum[ADDR_WIDTH];
        flags_d.free_match = (top_offset == check);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            flags_q   <= flags_d;
            size_q    <= size;
            align_q   <= align;
            aligned_q <= round_sum[ADDR_WIDTH-1:0] & ~amask;
            restore_q <= restore;
        end
    end

endmodule

/* tb/sv/aligned_stack_allocator_core_test.sv */
// self-checking testbench for the aligned stack allocator core
module aligned_stack_allocator_core_test;
    import asa_pkg::*;

    localparam int          DEPTH       = CURVE_DEPTH_DEF;
    localparam int unsigned CYCLE_LIMIT = 200_000;
    // the fourth command code has no meaning and must be ignored
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;

    // one command word, as the sender sees it
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] size;
        logic [31:0] align;
        logic [31:0] restore;
        logic [31:0] check;
    } cmd_word_t;

    // one line of the directed plan: a command word or a register write
    typedef enum bit {ROW_WORD, ROW_REG} row_kind_t;
    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  reg_idx;
        logic [31:0] reg_val;
        cmd_word_t   w;
        bit          typed;
        logic        ok;
        logic [2:0]  err;
    } plan_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [1:0]             cfg_index;
    logic [31:0]            cfg_wdata;

    aligned_stack_allocator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predicted allocator state, kept in step with every accepted word
    logic [31:0] region_size, region_base;
    logic        exec_phase;
    logic [31:0] top_off, peak_off, peak_align;
    logic        can_alloc, curve_flagged;
    int          curve_pos;
    logic [31:0] curve_vals [DEPTH];
    bit          curve_written [DEPTH];

    result_t     awaited_results [$];
    logic [63:0] open_frames [$];       // {restore, check} of live allocations, innermost last
    cmd_word_t   replay_log [$];
    plan_row_t   plan [$];

    bit          steady;                // when set neither side idles
    int          mismatches = 0;
    int          words_sent = 0;
    int          results_checked = 0;
    int          reg_writes = 0;
    int unsigned cycle_count = 0;

    // -------------------------------------------------------------------------
    // predictor: outcome of one accepted command word, updating the state copy
    // -------------------------------------------------------------------------
    function automatic result_t allocator_outcome(input cmd_word_t w);
        result_t     r;
        logic [31:0] amask, aligned, nxt;
        bit          hit;
        r = '0;
        case (w.cmd)
            CMD_ALLOC: begin
                amask   = w.align - 32'd1;
                aligned = (top_off + amask) & ~amask;
                nxt     = aligned + w.size;
                // error precedence follows the order of the checks below
                if (!can_alloc)
                    r.error_code = ERR_LOCKED;
                else if (w.align == '0 || (w.align & amask) != '0)
                    r.error_code = ERR_BAD_ALIGN;
                else if (top_off > ~amask || aligned > ~w.size)
                    r.error_code = ERR_OVERFLOW;    // rounding or size runs past the top
                else if (exec_phase && nxt > region_size)
                    r.error_code = ERR_NO_ROOM;
                else if (exec_phase && (region_base & amask) != '0)
                    r.error_code = ERR_BASE_MISALIGN;
                else begin
                    r.curve_warning = WARN_NONE;
                    if (!exec_phase) begin
                        // counting: record the curve, or flag a full store once
                        if (curve_pos < DEPTH) begin
                            curve_vals[curve_pos]    = nxt;
                            curve_written[curve_pos] = 1'b1;
                            curve_pos++;
                        end else if (!curve_flagged) begin
                            curve_flagged   = 1'b1;
                            r.curve_warning = WARN_CAPACITY;
                        end
                    end else begin
                        // execution: compare with the curve, past its end never matches
                        hit = 1'b0;
                        if (curve_pos < DEPTH) begin
                            hit = (curve_vals[curve_pos] == nxt);
                            curve_pos++;
                        end
                        if (!hit && !curve_flagged) begin
                            curve_flagged   = 1'b1;
                            r.curve_warning = WARN_MISMATCH;
                        end
                    end
                    r.ok             = 1'b1;
                    r.address        = exec_phase ? region_base + aligned : '0;
                    r.restore_offset = top_off;
                    r.check_offset   = nxt;
                    top_off          = nxt;
                    if (w.align > peak_align) peak_align = w.align;
                    if (nxt > peak_off) peak_off = nxt;
                end
            end
            CMD_FREE: begin
                // works while locked; a wrong check value locks the allocator
                if (top_off == w.check) begin
                    top_off = w.restore;
                    r.ok    = 1'b1;
                end else begin
                    can_alloc    = 1'b0;
                    r.error_code = ERR_FREE_MISMATCH;
                end
            end
            CMD_RESTART: begin
                // curve store and peaks survive a restart
                top_off       = '0;
                curve_pos     = 0;
                curve_flagged = 1'b0;
                can_alloc     = 1'b1;
                r.ok          = 1'b1;
            end
            default: ;
        endcase
        r.peak_offset    = peak_off;
        r.peak_alignment = peak_align;
        return r;
    endfunction

    // -------------------------------------------------------------------------
    // stimulus source: mostly well-formed nested alloc/free, some noise
    // -------------------------------------------------------------------------
    function automatic cmd_word_t draw_word(input bit chaos);
        cmd_word_t   w;
        logic [63:0] f;
        w.cmd     = CMD_ALLOC;
        w.size    = $urandom_range(0, 48);
        w.align   = 32'd1 << $urandom_range(0, 6);
        w.restore = $urandom;
        w.check   = $urandom;
        if (chaos && !can_alloc && $urandom_range(0, 2) == 0) begin
            w.cmd = CMD_RESTART;        // get out of the locked state now and then
        end else if ($urandom_range(0, chaos ? 3 : 9) != 0) begin
            if (open_frames.size() != 0 && $urandom_range(0, 2) == 0) begin
                f         = open_frames.pop_back();
                w.cmd     = CMD_FREE;
                w.restore = f[63:32];
                w.check   = f[31:0];
            end else if ($urandom_range(0, 15) == 0) begin
                w.size = $urandom_range(0, 4096);
            end
        end else begin
            case ($urandom_range(0, chaos ? 7 : 2))
                0: begin
                    w.cmd   = CMD_UNUSED;
                    w.size  = $urandom;
                    w.align = $urandom;
                end
                1: w.align = $urandom;                          // almost always bad
                2: w.size  = $urandom;                          // large, may overflow
                3: w.cmd   = CMD_RESTART;
                4: w.cmd   = CMD_FREE;                          // random check, likely locks
                5: begin
                    // matching check but an arbitrary restore: offset jumps anywhere
                    w.cmd   = CMD_FREE;
                    w.check = top_off;
                    open_frames.delete();
                end
                6: begin
                    w.size  = $urandom;
                    w.align = 32'd1 << $urandom_range(0, 31);
                end
                default: begin
                    w.cmd   = CMD_FREE;                         // stale check, off by one
                    w.check = top_off + 32'd1;
                end
            endcase
        end
        // never make the core read a curve entry that was never recorded
        if (w.cmd == CMD_ALLOC && exec_phase && curve_pos < DEPTH && !curve_written[curve_pos])
            w.cmd = CMD_RESTART;
        return w;
    endfunction

    function automatic plan_row_t known_row(input logic [1:0] cmd,
            input logic [31:0] size, align, restore, check, input logic ok,
            input logic [2:0] err);
        plan_row_t p;
        p       = '0;
        p.kind  = ROW_WORD;
        p.w     = '{cmd, size, align, restore, check};
        p.typed = 1'b1;
        p.ok    = ok;
        p.err   = err;
        return p;
    endfunction

    function automatic plan_row_t word_row(input logic [1:0] cmd,
            input logic [31:0] size, align, restore, check);
        plan_row_t p;
        p       = known_row(cmd, size, align, restore, check, 1'b0, ERR_NONE);
        p.typed = 1'b0;
        return p;
    endfunction

    function automatic plan_row_t reg_row(input logic [1:0] idx, input logic [31:0] val);
        plan_row_t p;
        p         = '0;
        p.kind    = ROW_REG;
        p.reg_idx = idx;
        p.reg_val = val;
        return p;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want, got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // -------------------------------------------------------------------------
    // drivers
    // -------------------------------------------------------------------------

    // drop the input, let every result drain, then idle before returning
    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_REGION_SIZE:   region_size = val;
            CFG_REGION_BASE:   region_base = val;
            CFG_EXECUTE_PHASE: exec_phase  = val[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // present one word, predict its result once accepted; typed rows carry their own status
    task automatic send_word(input cmd_word_t w, input bit typed, input logic ok,
            input logic [2:0] err);
        int      gap;
        result_t r;
        if ($urandom_range(0, 47) == 0) steady = ~steady;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.cmd;
        s_tdata  <= {w.check, w.restore, w.align, w.size};
        do @(posedge aclk); while (!s_tready);
        r = allocator_outcome(w);
        if (typed) begin
            r.ok         = ok;
            r.error_code = err;
        end
        awaited_results.push_back(r);
        words_sent++;
        // keep the list of live allocations usable for well-formed frees
        if (w.cmd == CMD_ALLOC && r.ok)
            open_frames.push_back({r.restore_offset, r.check_offset});
        else if (w.cmd == CMD_RESTART || (w.cmd == CMD_FREE && !r.ok))
            open_frames.delete();
    endtask

    // one register setting followed by a restart and a burst of mixed words
    task automatic run_phase(input logic [31:0] size, base, input logic exec, input int count);
        cmd_word_t w;
        write_reg(CFG_REGION_SIZE, size);
        write_reg(CFG_REGION_BASE, base);
        write_reg(CFG_EXECUTE_PHASE, {31'd0, exec});
        w         = '0;
        w.cmd     = CMD_RESTART;
        send_word(w, 1'b0, 1'b0, ERR_NONE);
        for (int n = 0; n < count; n++) begin
            send_word(draw_word(1'b1), 1'b0, 1'b0, ERR_NONE);
            if (n % 16 == 15) settle();     // sender holds off until all results are in
        end
    endtask

    // -------------------------------------------------------------------------
    // result side: random stalls, in-order compare against the predictions
    // -------------------------------------------------------------------------
    initial begin : result_sink
        result_t want, got;
        int      stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (awaited_results.size() == 0) begin
                $error("result word with nothing awaited: %0h", m_tdata);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                check_field("ok",             32'(want.ok),            32'(got.ok));
                check_field("error_code",     32'(want.error_code),    32'(got.error_code));
                check_field("address",        want.address,            got.address);
                check_field("restore_offset", want.restore_offset,     got.restore_offset);
                check_field("check_offset",   want.check_offset,       got.check_offset);
                check_field("curve_warning",  32'(want.curve_warning), 32'(got.curve_warning));
                check_field("peak_offset",    want.peak_offset,        got.peak_offset);
                check_field("peak_alignment", want.peak_alignment,     got.peak_alignment);
                results_checked++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // -------------------------------------------------------------------------
    // main sequence
    // -------------------------------------------------------------------------
    initial begin : stimulus
        cmd_word_t w;
        bit        bumped;
        int        extra;

        steady        = 1'b0;
        region_size   = '0;
        region_base   = '0;
        exec_phase    = 1'b0;
        top_off       = '0;
        peak_off      = '0;
        peak_align    = '0;
        can_alloc     = 1'b1;
        curve_flagged = 1'b0;
        curve_pos     = 0;
        foreach (curve_vals[i]) begin
            curve_vals[i]    = '0;
            curve_written[i] = 1'b0;
        end

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed plan, counting phase with reset registers first
        plan.push_back(known_row(CMD_ALLOC, 0, 1, 0, 0, 1'b1, ERR_NONE));
        plan.push_back(known_row(CMD_ALLOC, 5, 0, 0, 0, 1'b0, ERR_BAD_ALIGN));    // zero alignment
        plan.push_back(known_row(CMD_ALLOC, 5, 3, 0, 0, 1'b0, ERR_BAD_ALIGN));
        plan.push_back(word_row(CMD_ALLOC, 5, 32'h8000_0000, 0, 0));             // top alignment bit
        plan.push_back(word_row(CMD_ALLOC, 3, 8, 0, 0));
        plan.push_back(known_row(CMD_ALLOC, '1, 1, 0, 0, 1'b0, ERR_OVERFLOW));
        plan.push_back(word_row(CMD_ALLOC, 32'hFFFF_FFE5, 1, 0, 0));             // up to fff0
        plan.push_back(known_row(CMD_ALLOC, 0, 32, 0, 0, 1'b0, ERR_OVERFLOW));    // rounding
        plan.push_back(known_row(CMD_ALLOC, 16, 16, 0, 0, 1'b0, ERR_OVERFLOW));   // size
        plan.push_back(word_row(CMD_ALLOC, 15, 16, 0, 0));                       // ends at all ones
        plan.push_back(known_row(CMD_FREE, 0, 0, 11, 32'hFFFF_FFF0, 1'b0, ERR_FREE_MISMATCH));
        plan.push_back(known_row(CMD_ALLOC, 1, 1, 0, 0, 1'b0, ERR_LOCKED));
        plan.push_back(known_row(CMD_FREE, 0, 0, 32'hFFFF_FFF0, '1, 1'b1, ERR_NONE));
        plan.push_back(known_row(CMD_ALLOC, 1, 0, 0, 0, 1'b0, ERR_LOCKED));       // lock wins
        plan.push_back(known_row(CMD_UNUSED, '1, '1, '1, '1, 1'b0, ERR_NONE));
        plan.push_back(known_row(CMD_RESTART, 0, 0, 0, 0, 1'b1, ERR_NONE));
        plan.push_back(word_row(CMD_ALLOC, 7, 4, 0, 0));
        // execution phase: small region, base only two-byte aligned
        plan.push_back(reg_row(CFG_REGION_SIZE, 64));
        plan.push_back(reg_row(CFG_REGION_BASE, 32'h1000_0002));
        plan.push_back(reg_row(CFG_EXECUTE_PHASE, 1));
        plan.push_back(known_row(CMD_RESTART, 0, 0, 0, 0, 1'b1, ERR_NONE));
        plan.push_back(known_row(CMD_ALLOC, 100, 1, 0, 0, 1'b0, ERR_NO_ROOM));
        plan.push_back(known_row(CMD_ALLOC, 7, 4, 0, 0, 1'b0, ERR_BASE_MISALIGN));
        plan.push_back(word_row(CMD_ALLOC, 7, 2, 0, 0));                         // curve match
        plan.push_back(word_row(CMD_ALLOC, 2, 2, 0, 0));                         // first mismatch
        plan.push_back(word_row(CMD_ALLOC, 0, 1, 0, 0));                         // not flagged again
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                send_word(plan[i].w, plan[i].typed, plan[i].ok, plan[i].err);
        end

        // counting pass over the whole curve store and past its end, logged for replay
        write_reg(CFG_REGION_SIZE, '1);
        write_reg(CFG_REGION_BASE, '0);
        write_reg(CFG_EXECUTE_PHASE, 0);
        w     = '0;
        w.cmd = CMD_RESTART;
        replay_log.push_back(w);
        send_word(w, 1'b0, 1'b0, ERR_NONE);
        extra = 0;
        while (extra < 6) begin
            w = draw_word(1'b0);
            replay_log.push_back(w);
            send_word(w, 1'b0, 1'b0, ERR_NONE);
            if (curve_flagged) extra++;
        end

        // same words in execution: all match until the curve runs out
        write_reg(CFG_EXECUTE_PHASE, 1);
        foreach (replay_log[i]) send_word(replay_log[i], 1'b0, 1'b0, ERR_NONE);

        // replay the first part with one size nudged, giving a mid-curve mismatch
        bumped = 1'b0;
        foreach (replay_log[i]) begin
            if (i < 90) begin
                w = replay_log[i];
                if (!bumped && i >= 45 && w.cmd == CMD_ALLOC && w.align != '0
                        && (w.align & (w.align - 32'd1)) == '0) begin
                    w.size = w.size + 32'd1;
                    bumped = 1'b1;
                end
                send_word(w, 1'b0, 1'b0, ERR_NONE);
            end
        end

        // mixed traffic under several register settings, extremes included
        run_phase('0, '1, 1'b1, 40);
        run_phase($urandom_range(64, 4096), {26'($urandom_range(0, 32'h03FF_FFFF)), 6'd0},
                  1'b1, 40);
        run_phase($urandom, $urandom, 1'b0, 40);

        settle();
        repeat (6) @(posedge aclk);

        $display("covered %0d command words over %0d register writes; %0d results compared",
                 words_sent, reg_writes, results_checked);
        $display("curve recorded past capacity, replayed to its end and with a mismatch");
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/asa_pkg.sv
hdl/asa_ram.sv
hdl/asa_align.sv
hdl/aligned_stack_allocator_core.sv
tb/sv/aligned_stack_allocator_core_test.sv
